// File: sv/matrix4x4_inverse_macros.svh
// Assertion helpers for the matrix inverse block.
`ifndef MATRIX4X4_INVERSE_MACROS_SVH
`define MATRIX4X4_INVERSE_MACROS_SVH
`ifndef ASSERT_OFF
`define MI4_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MI4_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define MI4_ASSERT(lbl, clk, rst, prop, msg)
`define MI4_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: sv/mi4_pkg.sv
package mi4_pkg;

   localparam int EW            = 32;   // element width
   localparam int M2W           = 64;   // 2x2 minor
   localparam int COFW          = 98;   // cofactor
   localparam int DETW          = 132;  // determinant, also accumulator width
   localparam int QW            = 33;   // quotient bits kept, top one for overflow
   localparam int FRAC_BITS_DEF = 16;

   localparam logic [EW-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [EW-1:0] SAT_NEG = 32'h8000_0000;

   // multiply steps of one cofactor
   localparam logic [3:0] OP_M0A = 4'd0;
   localparam logic [3:0] OP_M0B = 4'd1;
   localparam logic [3:0] OP_M1A = 4'd2;
   localparam logic [3:0] OP_M1B = 4'd3;
   localparam logic [3:0] OP_M2A = 4'd4;
   localparam logic [3:0] OP_M2B = 4'd5;
   localparam logic [3:0] OP_C0  = 4'd6;
   localparam logic [3:0] OP_C1  = 4'd7;
   localparam logic [3:0] OP_C2  = 4'd8;

   typedef struct packed {
      logic start;
      logic clr;
      logic neg;
   } mac_ctl_type;

   typedef struct packed {
      logic [3:0] a_idx;
      logic [3:0] b_idx;
      logic       clr;
      logic       neg;
   } op_sel_type;

   // k-th index of 0..3 with x left out
   function automatic logic [1:0] skip(input logic [1:0] k, input logic [1:0] x);
      return (k < x) ? k : k + 2'd1;
   endfunction

   function automatic op_sel_type op_sel(input logic [1:0] r, input logic [1:0] c,
                                         input logic [3:0] op);
      logic [1:0] r0, r1, r2, c0, c1, c2;
      logic       odd;
      op_sel_type s;
      r0  = skip(2'd0, r);
      r1  = skip(2'd1, r);
      r2  = skip(2'd2, r);
      c0  = skip(2'd0, c);
      c1  = skip(2'd1, c);
      c2  = skip(2'd2, c);
      odd = r[0] ^ c[0];
      s   = '0;
      case (op)
         OP_M0A: begin s.a_idx = {r1, c1}; s.b_idx = {r2, c2}; s.clr = 1'b1; end
         OP_M0B: begin s.a_idx = {r1, c2}; s.b_idx = {r2, c1}; s.neg = 1'b1; end
         OP_M1A: begin s.a_idx = {r1, c0}; s.b_idx = {r2, c2}; s.clr = 1'b1; end
         OP_M1B: begin s.a_idx = {r1, c2}; s.b_idx = {r2, c0}; s.neg = 1'b1; end
         OP_M2A: begin s.a_idx = {r1, c0}; s.b_idx = {r2, c1}; s.clr = 1'b1; end
         OP_M2B: begin s.a_idx = {r1, c1}; s.b_idx = {r2, c0}; s.neg = 1'b1; end
         OP_C0:  begin s.b_idx = {r0, c0}; s.clr = 1'b1; s.neg = odd; end
         OP_C1:  begin s.b_idx = {r0, c1}; s.neg = ~odd; end
         OP_C2:  begin s.b_idx = {r0, c2}; s.neg = odd; end
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

// File: sv/mi4_mac.sv
module mi4_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mi4_pkg::mac_ctl_type                 ctl,
   input  logic signed [mi4_pkg::DETW-1:0]      a,
   input  logic signed [mi4_pkg::EW-1:0]        b,
   output logic                                 busy,
   output logic                                 done,
   output logic signed [mi4_pkg::DETW-1:0]      acc
);

   logic [mi4_pkg::DETW-1:0] mcand_ff;
   logic [mi4_pkg::DETW-1:0] acc_ff;
   logic [mi4_pkg::DETW-1:0] addend;
   logic [mi4_pkg::EW-1:0]   b_ff;
   logic [4:0]               cnt_ff;
   logic                     neg_ff;
   logic                     busy_ff;
   logic                     done_ff;
   logic                     sub;
   logic                     last_step;

   // sign bit of b carries negative weight
   assign last_step = (cnt_ff == 5'd31);
   assign sub       = neg_ff ^ last_step;
   assign addend    = sub ? (~mcand_ff + 1'b1) : mcand_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && last_step;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (last_step) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         mcand_ff <= a;
         b_ff     <= b;
         neg_ff   <= ctl.neg;
         if (ctl.clr) begin
            acc_ff <= '0;
         end
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_ff <= acc_ff + addend;
         end
         mcand_ff <= {mcand_ff[mi4_pkg::DETW-2:0], 1'b0};
         b_ff     <= {1'b0, b_ff[mi4_pkg::EW-1:1]};
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign acc  = acc_ff;

endmodule

// File: sv/mi4_div.sv
module mi4_div #(
   parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [mi4_pkg::COFW-1:0]   num,
   input  logic [mi4_pkg::DETW-1:0]          den,
   input  logic                              den_neg,
   output logic                              busy,
   output logic                              done,
   output logic [mi4_pkg::EW-1:0]            quot,
   output logic                              sat
);

   localparam int NW = mi4_pkg::COFW + 2 * FRAC_BITS;
   localparam int CW = $clog2(NW);

   logic [NW-1:0]                n_ff;
   logic [mi4_pkg::DETW-1:0]     rem_ff;
   logic [mi4_pkg::DETW-1:0]     den_ff;
   logic [mi4_pkg::QW-1:0]       q_ff;
   logic                         big_ff;
   logic                         sneg_ff;
   logic [CW-1:0]                cnt_ff;
   logic                         busy_ff;
   logic                         done_ff;
   logic [mi4_pkg::COFW-1:0]     mag;
   logic [mi4_pkg::DETW:0]       part;
   logic [mi4_pkg::DETW+1:0]     diff;
   logic                         ge;
   logic                         last_step;
   logic                         pos_sat;
   logic                         neg_sat;

   assign mag       = num[mi4_pkg::COFW-1] ? (~num + 1'b1) : num;
   assign part      = {rem_ff, n_ff[NW-1]};
   assign diff      = {1'b0, part} - {2'b00, den_ff};
   assign ge        = ~diff[mi4_pkg::DETW+1];
   assign last_step = (cnt_ff == CW'(NW - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && last_step;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last_step) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         n_ff    <= {mag, {(2 * FRAC_BITS){1'b0}}};
         rem_ff  <= '0;
         den_ff  <= den;
         q_ff    <= '0;
         big_ff  <= 1'b0;
         sneg_ff <= num[mi4_pkg::COFW-1] ^ den_neg;
      end else if (busy_ff) begin
         n_ff   <= {n_ff[NW-2:0], 1'b0};
         rem_ff <= ge ? diff[mi4_pkg::DETW-1:0] : part[mi4_pkg::DETW-1:0];
         q_ff   <= {q_ff[mi4_pkg::QW-2:0], ge};
         // anything shifted past the kept quotient bits means overflow
         big_ff <= big_ff | q_ff[mi4_pkg::QW-1];
      end
   end

   assign pos_sat = big_ff | q_ff[32] | q_ff[31];
   assign neg_sat = big_ff | q_ff[32] | (q_ff[31] & (|q_ff[30:0]));

   always_comb begin
      if (sneg_ff) begin
         sat  = neg_sat;
         quot = neg_sat ? mi4_pkg::SAT_NEG : (~q_ff[31:0] + 1'b1);
      end else begin
         sat  = pos_sat;
         quot = pos_sat ? mi4_pkg::SAT_POS : q_ff[31:0];
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;

endmodule

// File: sv/matrix4x4_inverse.sv
// Channel   Direction  Ports                                  Transfer
// req       in         req_col0..3                            req_valid & req_ready
// rsp       out        rsp_row_index, rsp_inv_col0..3, flags  rsp_valid & rsp_ready
//
// Rows 0..2 are stored one per transfer. The fourth row starts the solve:
// 148 multiply steps on the shift-add unit, then 16 quotients on the
// restoring divider. A singular matrix skips the division.
// Synchronous reset clears the row count and the sequencer; a stalled rsp holds
// the sequencer only when the next row is ready to be loaded.
`include "matrix4x4_inverse_macros.svh"

module matrix4x4_inverse #(
   parameter int FRAC_BITS = mi4_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [31:0]            req_col0,
   input  logic signed [31:0]            req_col1,
   input  logic signed [31:0]            req_col2,
   input  logic signed [31:0]            req_col3,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_row_index,
   output logic signed [31:0]            rsp_inv_col0,
   output logic signed [31:0]            rsp_inv_col1,
   output logic signed [31:0]            rsp_inv_col2,
   output logic signed [31:0]            rsp_inv_col3,
   output logic                          rsp_singular,
   output logic                          rsp_saturated,
   output logic                          rsp_last
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_OPA   = 9'b000000010,
      S_OPB   = 9'b000000100,
      S_MWAIT = 9'b000001000,
      S_DCHK  = 9'b000010000,
      S_SOUT  = 9'b000100000,
      S_DIVS  = 9'b001000000,
      S_DWAIT = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   localparam int EW   = mi4_pkg::EW;
   localparam int DETW = mi4_pkg::DETW;
   localparam int COFW = mi4_pkg::COFW;
   localparam int M2W  = mi4_pkg::M2W;

   state_type                state_ff, state_in;
   logic [1:0]               row_cnt_ff, row_cnt_in;
   logic [3:0]               ci_ff, ci_in;
   logic [3:0]               op_ff, op_in;
   logic                     det_ph_ff, det_ph_in;
   logic [1:0]               orow_ff, orow_in;
   logic [1:0]               ocol_ff, ocol_in;
   logic                     rowsat_ff, rowsat_in;

   logic [EW-1:0]            mat_ff [16];
   logic [M2W-1:0]           m2_ff [3];
   logic [COFW-1:0]          cof_ff [16];
   logic [EW-1:0]            rowbuf_ff [4];
   logic [DETW-1:0]          a_ff, a_in;
   logic [DETW-1:0]          dmag_ff;
   logic                     dneg_ff;

   logic                     rsp_valid_ff;
   logic [1:0]               rsp_row_index_ff;
   logic [EW-1:0]            rsp_col_ff [4];
   logic                     rsp_singular_ff;
   logic                     rsp_saturated_ff;
   logic                     rsp_last_ff;

   logic                     in_xfer;
   logic                     out_free;
   logic                     mat_we, cof_we, rowbuf_we, a_we, det_we;
   logic [2:0]               m2_we;
   logic                     load_row, load_sing;
   mi4_pkg::op_sel_type      sel;
   logic [3:0]               rd_idx, cof_idx;
   logic [EW-1:0]            elem;
   logic [COFW-1:0]          cof_rd;
   mi4_pkg::mac_ctl_type     mac_ctl;
   logic                     mac_busy, mac_done;
   logic signed [DETW-1:0]   mac_acc;
   logic                     div_start, div_busy, div_done, div_sat;
   logic [EW-1:0]            div_quot;

   assign req_ready = (state_ff == S_IDLE);
   assign in_xfer   = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign sel     = mi4_pkg::op_sel(ci_ff[3:2], ci_ff[1:0], op_ff);
   assign rd_idx  = det_ph_ff ? {2'b00, op_ff[1:0]} :
                    ((state_ff == S_OPA) ? sel.a_idx : sel.b_idx);
   assign elem    = mat_ff[rd_idx];
   assign cof_idx = (state_ff == S_DIVS) ? {ocol_ff, orow_ff} : {2'b00, op_ff[1:0]};
   assign cof_rd  = cof_ff[cof_idx];

   always_comb begin
      state_in   = state_ff;
      row_cnt_in = row_cnt_ff;
      ci_in      = ci_ff;
      op_in      = op_ff;
      det_ph_in  = det_ph_ff;
      orow_in    = orow_ff;
      ocol_in    = ocol_ff;
      rowsat_in  = rowsat_ff;
      a_in       = {{(DETW-EW){elem[EW-1]}}, elem};
      mat_we     = 1'b0;
      cof_we     = 1'b0;
      rowbuf_we  = 1'b0;
      a_we       = 1'b0;
      det_we     = 1'b0;
      m2_we      = 3'b000;
      load_row   = 1'b0;
      load_sing  = 1'b0;
      mac_ctl    = '0;
      div_start  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (in_xfer) begin
               mat_we = 1'b1;
               if (row_cnt_ff == 2'd3) begin
                  row_cnt_in = 2'd0;
                  ci_in      = 4'd0;
                  op_in      = mi4_pkg::OP_M0A;
                  det_ph_in  = 1'b0;
                  state_in   = S_OPA;
               end else begin
                  row_cnt_in = row_cnt_ff + 2'd1;
               end
            end
         end
         S_OPA: begin
            a_we = 1'b1;
            if (det_ph_ff) begin
               a_in = {{(DETW-COFW){cof_rd[COFW-1]}}, cof_rd};
            end else if (op_ff == mi4_pkg::OP_C0) begin
               a_in = {{(DETW-M2W){m2_ff[0][M2W-1]}}, m2_ff[0]};
            end else if (op_ff == mi4_pkg::OP_C1) begin
               a_in = {{(DETW-M2W){m2_ff[1][M2W-1]}}, m2_ff[1]};
            end else if (op_ff == mi4_pkg::OP_C2) begin
               a_in = {{(DETW-M2W){m2_ff[2][M2W-1]}}, m2_ff[2]};
            end
            state_in = S_OPB;
         end
         S_OPB: begin
            mac_ctl.start = 1'b1;
            mac_ctl.clr   = det_ph_ff ? (op_ff[1:0] == 2'd0) : sel.clr;
            mac_ctl.neg   = det_ph_ff ? 1'b0 : sel.neg;
            state_in      = S_MWAIT;
         end
         S_MWAIT: begin
            if (mac_done) begin
               state_in = S_OPA;
               op_in    = op_ff + 4'd1;
               if (det_ph_ff) begin
                  if (op_ff[1:0] == 2'd3) begin
                     state_in = S_DCHK;
                  end
               end else begin
                  if (op_ff == mi4_pkg::OP_M0B) m2_we[0] = 1'b1;
                  if (op_ff == mi4_pkg::OP_M1B) m2_we[1] = 1'b1;
                  if (op_ff == mi4_pkg::OP_M2B) m2_we[2] = 1'b1;
                  if (op_ff == mi4_pkg::OP_C2) begin
                     cof_we = 1'b1;
                     op_in  = mi4_pkg::OP_M0A;
                     if (ci_ff == 4'd15) begin
                        det_ph_in = 1'b1;
                     end else begin
                        ci_in = ci_ff + 4'd1;
                     end
                  end
               end
            end
         end
         S_DCHK: begin
            det_we = 1'b1;
            if (mac_acc == '0) begin
               state_in = S_SOUT;
            end else begin
               orow_in   = 2'd0;
               ocol_in   = 2'd0;
               rowsat_in = 1'b0;
               state_in  = S_DIVS;
            end
         end
         S_SOUT: begin
            if (out_free) begin
               load_sing = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_DIVS: begin
            div_start = 1'b1;
            state_in  = S_DWAIT;
         end
         S_DWAIT: begin
            if (div_done) begin
               rowbuf_we = 1'b1;
               rowsat_in = rowsat_ff | div_sat;
               if (ocol_ff == 2'd3) begin
                  state_in = S_OUT;
               end else begin
                  ocol_in  = ocol_ff + 2'd1;
                  state_in = S_DIVS;
               end
            end
         end
         S_OUT: begin
            if (out_free) begin
               load_row  = 1'b1;
               rowsat_in = 1'b0;
               ocol_in   = 2'd0;
               if (orow_ff == 2'd3) begin
                  state_in = S_IDLE;
               end else begin
                  orow_in  = orow_ff + 2'd1;
                  state_in = S_DIVS;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_cnt_ff   <= '0;
         ci_ff        <= '0;
         op_ff        <= '0;
         det_ph_ff    <= 1'b0;
         orow_ff      <= '0;
         ocol_ff      <= '0;
         rowsat_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         row_cnt_ff <= row_cnt_in;
         ci_ff      <= ci_in;
         op_ff      <= op_in;
         det_ph_ff  <= det_ph_in;
         orow_ff    <= orow_in;
         ocol_ff    <= ocol_in;
         rowsat_ff  <= rowsat_in;
         if (load_row || load_sing) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mat_we) begin
         mat_ff[{row_cnt_ff, 2'd0}] <= req_col0;
         mat_ff[{row_cnt_ff, 2'd1}] <= req_col1;
         mat_ff[{row_cnt_ff, 2'd2}] <= req_col2;
         mat_ff[{row_cnt_ff, 2'd3}] <= req_col3;
      end
      if (a_we) a_ff <= a_in;
      for (int k = 0; k < 3; k++) begin
         if (m2_we[k]) m2_ff[k] <= mac_acc[M2W-1:0];
      end
      if (cof_we) cof_ff[ci_ff] <= mac_acc[COFW-1:0];
      if (det_we) begin
         dneg_ff <= mac_acc[DETW-1];
         dmag_ff <= mac_acc[DETW-1] ? (~mac_acc + 1'b1) : mac_acc;
      end
      if (rowbuf_we) rowbuf_ff[ocol_ff] <= div_quot;
      if (load_sing) begin
         rsp_row_index_ff <= 2'd0;
         for (int k = 0; k < 4; k++) rsp_col_ff[k] <= '0;
         rsp_singular_ff  <= 1'b1;
         rsp_saturated_ff <= 1'b0;
         rsp_last_ff      <= 1'b1;
      end else if (load_row) begin
         rsp_row_index_ff <= orow_ff;
         for (int k = 0; k < 4; k++) rsp_col_ff[k] <= rowbuf_ff[k];
         rsp_singular_ff  <= 1'b0;
         rsp_saturated_ff <= rowsat_ff;
         rsp_last_ff      <= (orow_ff == 2'd3);
      end
   end

   mi4_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .a     (a_ff),
      .b     (elem),
      .busy  (mac_busy),
      .done  (mac_done),
      .acc   (mac_acc)
   );

   mi4_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (cof_rd),
      .den     (dmag_ff),
      .den_neg (dneg_ff),
      .busy    (div_busy),
      .done    (div_done),
      .quot    (div_quot),
      .sat     (div_sat)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_index = rsp_row_index_ff;
   assign rsp_inv_col0  = rsp_col_ff[0];
   assign rsp_inv_col1  = rsp_col_ff[1];
   assign rsp_inv_col2  = rsp_col_ff[2];
   assign rsp_inv_col3  = rsp_col_ff[3];
   assign rsp_singular  = rsp_singular_ff;
   assign rsp_saturated = rsp_saturated_ff;
   assign rsp_last      = rsp_last_ff;

   `MI4_ASSERT(a_units_excl, clock, reset, !(mac_busy && div_busy), "mac and divider both busy")
   `MI4_ASSERT(a_sing_last, clock, reset, !(rsp_valid_ff && rsp_singular_ff) || rsp_last_ff, "singular item not last")
   `MI4_ASSERT_NEXT(a_fourth_row, clock, reset, (in_xfer && row_cnt_ff == 2'd3), !req_ready, "fourth row did not start solve")

endmodule
